// ===== rtl/pamt_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the priority aging message table.
// No dependencies; every other rtl file uses this package.
package pamt_pkg;

  // Field widths of one request and one result
  localparam int ACTION_W  = 2;
  localparam int GROUP_W   = 4;
  localparam int KIND_W    = 3;
  localparam int CONTENT_W = 4;
  localparam int PRIO_W    = 16;
  localparam int INFO_W    = 16;
  localparam int TAKER_W   = 8;
  localparam int POS_W     = 5;
  localparam int STATUS_W  = 2;
  localparam int COUNT_W   = 6;

  localparam logic [PRIO_W-1:0] PRIO_MAX = '1;

  // Result status codes
  localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_POST   = 2'd0,
    ACT_GET    = 2'd1,
    ACT_AGE    = 2'd2,
    ACT_RETIRE = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  // One stored message (the active flag lives in flops beside the memory)
  typedef struct packed {
    logic [GROUP_W-1:0]   group;
    logic [KIND_W-1:0]    kind;
    logic [CONTENT_W-1:0] content;
    logic [PRIO_W-1:0]    prio;
    logic                 general;
    logic                 taken;
    logic [INFO_W-1:0]    info;
    logic [TAKER_W-1:0]   taker;
  } entry_t;

  // Shared compare / aging unit operands
  typedef struct packed {
    logic               age_mode;
    logic               active;
    entry_t             ent;
    logic [GROUP_W-1:0] group;
    logic [KIND_W-1:0]  kind;
    logic               match;
    logic               have;
    logic [PRIO_W-1:0]  best_prio;
  } alu_req_t;

  typedef struct packed {
    logic              take;
    logic [PRIO_W-1:0] aged_prio;
  } alu_rsp_t;

endpackage

// ===== rtl/pamt_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for requests and results of the message table.
// Depends on pamt_pkg for field widths.
interface pamt_in_if;
  logic                            valid;
  logic                            ready;
  logic [pamt_pkg::ACTION_W-1:0]   action;
  logic [pamt_pkg::GROUP_W-1:0]    target_group;
  logic [pamt_pkg::KIND_W-1:0]     msg_kind;
  logic                            match_kind;
  logic [pamt_pkg::CONTENT_W-1:0]  content_code;
  logic [pamt_pkg::PRIO_W-1:0]     start_priority;
  logic                            general_flag;
  logic                            taken_flag;
  logic [pamt_pkg::INFO_W-1:0]     info_tag;
  logic [pamt_pkg::TAKER_W-1:0]    taker_id;
  logic [pamt_pkg::POS_W-1:0]      position;

  modport source (
    output valid, action, target_group, msg_kind, match_kind, content_code,
           start_priority, general_flag, taken_flag, info_tag, taker_id, position,
    input  ready
  );
  modport sink (
    input  valid, action, target_group, msg_kind, match_kind, content_code,
           start_priority, general_flag, taken_flag, info_tag, taker_id, position,
    output ready
  );
endinterface

interface pamt_out_if;
  logic                            valid;
  logic                            ready;
  logic [pamt_pkg::STATUS_W-1:0]   status;
  logic                            found;
  logic [pamt_pkg::POS_W-1:0]      found_position;
  logic [pamt_pkg::PRIO_W-1:0]     found_priority;
  logic [pamt_pkg::CONTENT_W-1:0]  found_content;
  logic [pamt_pkg::KIND_W-1:0]     found_kind;
  logic [pamt_pkg::INFO_W-1:0]     found_info;
  logic [pamt_pkg::COUNT_W-1:0]    entry_count;

  modport source (
    output valid, status, found, found_position, found_priority, found_content,
           found_kind, found_info, entry_count,
    input  ready
  );
  modport sink (
    input  valid, status, found, found_position, found_priority, found_content,
           found_kind, found_info, entry_count,
    output ready
  );
endinterface

// ===== rtl/priority_aging_message_table.sv =====
`timescale 1ns / 1ps
// Priority message table with aging: post, get, age and retire requests.
// Depends on pamt_pkg, pamt_if, pamt_ram and pamt_alu.
//
// Entries sit in insertion order in a single-port-read entry memory. Post and retire
// are settled when accepted and then go straight to the result. Get and age walk
// the stored entries one per cycle through the memory read port and the shared
// compare/aging unit: the walk, then a drain of the read pipeline, then the close
// of the scan, then the hand-over of the result. Age compacts in place as it walks.
// The block accepts a new request only when the previous one has finished, but a
// finished result waits in an output register so the next request can start before
// it is taken. A table of TABLE_DEPTH entries needs no clearing pass after reset.
module priority_aging_message_table #(
  parameter int TABLE_DEPTH = 32
) (
  input logic         clk,
  input logic         rst,
  pamt_in_if.sink     req,
  pamt_out_if.source  rsp
);
  import pamt_pkg::*;

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  state_t state, state_next;

  logic [CNT_W-1:0]   held;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   wr_ptr;
  logic               rd_vld;
  logic [IDX_W-1:0]   rd_idx;
  logic               have;
  logic [IDX_W-1:0]   best_idx;
  entry_t             best_ent;
  action_t            op;
  logic [GROUP_W-1:0] q_group;
  logic [KIND_W-1:0]  q_kind;
  logic               q_match;
  logic [TAKER_W-1:0] q_taker;
  logic [TABLE_DEPTH-1:0] active;

  // Pending result and output register
  logic [STATUS_W-1:0]  res_status, out_status;
  logic                 res_found, out_found;
  logic [POS_W-1:0]     res_pos, out_pos;
  logic [PRIO_W-1:0]    res_prio, out_prio;
  logic [CONTENT_W-1:0] res_content, out_content;
  logic [KIND_W-1:0]    res_kind, out_kind;
  logic [INFO_W-1:0]    res_info, out_info;
  logic [COUNT_W-1:0]   res_count, out_count;
  logic                 out_valid;

  // Datapath control
  logic             accept;
  action_t          req_action;
  logic [CMP_W-1:0] pos_ext, held_ext;
  logic             pos_bad;
  logic             issue, scan_end, out_load;
  logic             post_ok, retire_ok, age_keep, get_take, get_wb;
  logic             we;
  logic [IDX_W-1:0] waddr, raddr;
  entry_t           wdata, rd_data;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  assign req.ready  = (state == ST_IDLE);
  assign accept     = req.valid && req.ready;
  assign req_action = action_t'(req.action);
  assign pos_ext    = CMP_W'(req.position);
  assign held_ext   = CMP_W'(held);
  assign pos_bad    = pos_ext >= held_ext;

  assign issue    = (state == ST_SCAN) && (idx < held);
  assign scan_end = (state == ST_SCAN) && !issue && !rd_vld;
  assign out_load = (state == ST_DONE) && (!out_valid || rsp.ready);

  assign post_ok   = accept && (req_action == ACT_POST) && (held < DEPTH_CNT);
  assign retire_ok = accept && (req_action == ACT_RETIRE) && !pos_bad;
  assign age_keep  = (state == ST_SCAN) && rd_vld && (op == ACT_AGE) && active[rd_idx];
  assign get_take  = (state == ST_SCAN) && rd_vld && alu_rsp.take;
  assign get_wb    = scan_end && (op == ACT_GET) && have;

  // Shared unit operands
  always_comb begin
    alu_req.age_mode  = (op == ACT_AGE);
    alu_req.active    = active[rd_idx];
    alu_req.ent       = rd_data;
    alu_req.group     = q_group;
    alu_req.kind      = q_kind;
    alu_req.match     = q_match;
    alu_req.have      = have;
    alu_req.best_prio = best_ent.prio;
  end

  pamt_alu u_alu (
    .req (alu_req),
    .rsp (alu_rsp)
  );

  // Memory write port: post append, age compaction, get taker writeback
  always_comb begin
    we    = 1'b0;
    waddr = best_idx;
    wdata = best_ent;
    priority if (post_ok) begin
      we            = 1'b1;
      waddr         = held[IDX_W-1:0];
      wdata.group   = req.target_group;
      wdata.kind    = req.msg_kind;
      wdata.content = req.content_code;
      wdata.prio    = req.start_priority;
      wdata.general = req.general_flag;
      wdata.taken   = req.taken_flag;
      wdata.info    = req.info_tag;
      wdata.taker   = '0;
    end else if (age_keep) begin
      we         = 1'b1;
      waddr      = wr_ptr[IDX_W-1:0];
      wdata      = rd_data;
      wdata.prio = alu_rsp.aged_prio;
    end else if (get_wb) begin
      we          = 1'b1;
      wdata.taker = q_taker;
    end
  end

  assign raddr = idx[IDX_W-1:0];

  pamt_ram #(
    .DEPTH (TABLE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rd_data)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if ((req_action == ACT_GET) || (req_action == ACT_AGE)) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= '0;
      rd_vld    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      rd_vld <= issue;
      if (post_ok) begin
        held <= held + CNT_W'(1);
      end else if (scan_end && (op == ACT_AGE)) begin
        held <= wr_ptr;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Active flags: set on post and on compaction, cleared by retire
  always_ff @(posedge clk) begin
    if (post_ok) begin
      active[held[IDX_W-1:0]] <= 1'b1;
    end
    if (retire_ok) begin
      active[pos_ext[IDX_W-1:0]] <= 1'b0;
    end
    if (age_keep) begin
      active[wr_ptr[IDX_W-1:0]] <= 1'b1;
    end
  end

  // Request capture, scan bookkeeping and result assembly
  always_ff @(posedge clk) begin
    rd_idx <= idx[IDX_W-1:0];
    if (accept) begin
      op          <= req_action;
      q_group     <= req.target_group;
      q_kind      <= req.msg_kind;
      q_match     <= req.match_kind;
      q_taker     <= req.taker_id;
      idx         <= '0;
      wr_ptr      <= '0;
      have        <= 1'b0;
      res_status  <= STAT_OK;
      res_found   <= 1'b0;
      res_pos     <= '0;
      res_prio    <= '0;
      res_content <= '0;
      res_kind    <= '0;
      res_info    <= '0;
      res_count   <= COUNT_W'(held);
      unique case (req_action)
        ACT_POST: begin
          if (held >= DEPTH_CNT) begin
            res_status <= STAT_FULL;
          end else begin
            res_pos   <= POS_W'(held);
            res_count <= COUNT_W'(held + CNT_W'(1));
          end
        end
        ACT_RETIRE: begin
          if (pos_bad) begin
            res_status <= STAT_RANGE;
          end
        end
        ACT_GET, ACT_AGE: begin
        end
      endcase
    end
    if (issue) begin
      idx <= idx + CNT_W'(1);
    end
    if (age_keep) begin
      wr_ptr <= wr_ptr + CNT_W'(1);
    end
    if (get_take) begin
      have     <= 1'b1;
      best_idx <= rd_idx;
      best_ent <= rd_data;
    end
    // Final result of a scan
    if (scan_end) begin
      if (op == ACT_AGE) begin
        res_count <= COUNT_W'(wr_ptr);
      end else if (have) begin
        res_found   <= 1'b1;
        res_pos     <= POS_W'(best_idx);
        res_prio    <= best_ent.prio;
        res_content <= best_ent.content;
        res_kind    <= best_ent.kind;
        res_info    <= best_ent.info;
      end
    end
    if (out_load) begin
      out_status  <= res_status;
      out_found   <= res_found;
      out_pos     <= res_pos;
      out_prio    <= res_prio;
      out_content <= res_content;
      out_kind    <= res_kind;
      out_info    <= res_info;
      out_count   <= res_count;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.status         = out_status;
  assign rsp.found          = out_found;
  assign rsp.found_position = out_pos;
  assign rsp.found_priority = out_prio;
  assign rsp.found_content  = out_content;
  assign rsp.found_kind     = out_kind;
  assign rsp.found_info     = out_info;
  assign rsp.entry_count    = out_count;

endmodule

// ===== rtl/pamt_ram.sv =====
`timescale 1ns / 1ps
// Entry memory: one write port, one read port with registered read data.
// Depends on pamt_pkg for the entry layout.
module pamt_ram #(
  parameter int DEPTH = 32,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  pamt_pkg::entry_t wdata,
  input  logic [IDX_W-1:0] raddr,
  output pamt_pkg::entry_t rdata
);
  import pamt_pkg::*;

  entry_t mem [DEPTH];

  // Registered write and registered read; a same-address read returns the old data
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/pamt_alu.sv =====
`timescale 1ns / 1ps
// Shared per-entry unit: priority compare for get, saturating increment for age.
// Depends on pamt_pkg.
module pamt_alu (
  input  pamt_pkg::alu_req_t req,
  output pamt_pkg::alu_rsp_t rsp
);
  import pamt_pkg::*;

  logic eligible;
  logic higher;

  // Candidate filter and ranking; earlier entry keeps a tie
  always_comb begin
    eligible = req.active && !req.ent.taken && (req.ent.group == req.group) &&
               (!req.match || (req.ent.kind == req.kind));
    higher   = req.ent.prio > req.best_prio;
    rsp.take = !req.age_mode && eligible && (!req.have || higher);
    // Aging: non-general entries gain one, stopping at the top
    if (req.ent.general || (req.ent.prio == PRIO_MAX)) begin
      rsp.aged_prio = req.ent.prio;
    end else begin
      rsp.aged_prio = req.ent.prio + PRIO_W'(1);
    end
  end

endmodule

// ===== rtl/pamt_chk.sv =====
`timescale 1ns / 1ps
// Port-level checks for the message table, bound onto the top level.
// Depends on pamt_pkg for status codes and widths.
module pamt_chk (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_ready,
  input logic                           rsp_valid,
  input logic                           rsp_ready,
  input logic [pamt_pkg::STATUS_W-1:0]  rsp_status,
  input logic                           rsp_found,
  input logic [pamt_pkg::POS_W-1:0]     rsp_found_position,
  input logic [pamt_pkg::PRIO_W-1:0]    rsp_found_priority,
  input logic [pamt_pkg::CONTENT_W-1:0] rsp_found_content,
  input logic [pamt_pkg::KIND_W-1:0]    rsp_found_kind,
  input logic [pamt_pkg::INFO_W-1:0]    rsp_found_info
);
  import pamt_pkg::*;

  // A request keeps the block busy for at least the next cycle
  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready stayed high right after a request");

  // Only defined status codes appear
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp_status == STAT_OK) || (rsp_status == STAT_FULL) ||
                  (rsp_status == STAT_RANGE))
    else $error("undefined status code");

  // Without a selected entry the entry fields read zero
  a_clear_fields: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_found |-> (rsp_found_priority == '0) &&
      (rsp_found_content == '0) && (rsp_found_kind == '0) && (rsp_found_info == '0))
    else $error("entry fields set without a selected entry");

  // A failed request never reports a selection or a position
  a_error_clean: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp_status != STAT_OK) |-> !rsp_found && (rsp_found_position == '0))
    else $error("error result carries a selection");

  // A stalled result stays offered
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_found))
    else $error("result dropped or changed while stalled");

endmodule

bind priority_aging_message_table pamt_chk u_pamt_chk (
  .clk                (clk),
  .rst                (rst),
  .req_valid          (req.valid),
  .req_ready          (req.ready),
  .rsp_valid          (rsp.valid),
  .rsp_ready          (rsp.ready),
  .rsp_status         (rsp.status),
  .rsp_found          (rsp.found),
  .rsp_found_position (rsp.found_position),
  .rsp_found_priority (rsp.found_priority),
  .rsp_found_content  (rsp.found_content),
  .rsp_found_kind     (rsp.found_kind),
  .rsp_found_info     (rsp.found_info)
);
